[src/rggb_pkg.sv]
// Shared types and constants for the radial glow blend pipeline.
package rggb_pkg;

    localparam int MAX_SIDE_DEF = 1024;
    localparam int QUOT_BITS    = 32;
    localparam int ROOT_BITS    = 16;
    localparam int CHAN_BITS    = 8;

    typedef struct packed {
        logic                 bypass;
        logic [CHAN_BITS-1:0] alpha;
        logic [CHAN_BITS-1:0] red;
        logic [CHAN_BITS-1:0] green;
        logic [CHAN_BITS-1:0] blue;
    } side_t;

endpackage

[src/rggb_geom.sv]
// Anchor selection, squared distance and scaled divisor, two stages.
module rggb_geom #(
    parameter int MAX_SIDE = rggb_pkg::MAX_SIDE_DEF,
    parameter int SW       = $clog2(MAX_SIDE + 1),
    parameter int XW       = ((SW > 10) ? SW : 10) + 2,
    parameter int DDW      = 2 * SW + 6
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            in_vld,
    input  rggb_pkg::side_t in_side,
    input  logic [9:0]      pos_x,
    input  logic [9:0]      pos_y,
    input  logic [SW-1:0]   side_w,
    input  logic [SW-1:0]   side_h,
    input  logic [3:0]      origin,
    output logic            out_vld,
    output rggb_pkg::side_t out_side,
    output logic [DDW-1:0]  out_rem,
    output logic [DDW-1:0]  out_dvs,
    output logic            out_sat
);
    import rggb_pkg::*;

    localparam int DW = 2 * XW;
    localparam int TW = 2 * SW + 1;

    typedef enum logic [3:0] {
        ORG_TOP_LEFT   = 4'd0,
        ORG_LEFT_Q1    = 4'd1,
        ORG_LEFT_MID   = 4'd2,
        ORG_LEFT_Q3    = 4'd3,
        ORG_BOT_LEFT   = 4'd4,
        ORG_BOT_Q1     = 4'd5,
        ORG_BOT_MID    = 4'd6,
        ORG_BOT_Q3     = 4'd7,
        ORG_BOT_RIGHT  = 4'd8,
        ORG_RIGHT_Q3   = 4'd9,
        ORG_RIGHT_MID  = 4'd10,
        ORG_RIGHT_Q1   = 4'd11,
        ORG_TOP_RIGHT  = 4'd12,
        ORG_TOP_Q3     = 4'd13,
        ORG_TOP_MID    = 4'd14,
        ORG_TOP_Q1     = 4'd15
    } anchor_t;

    logic [SW+1:0]        w3;
    logic [SW+1:0]        h3;
    logic signed [XW-1:0] w_m1, w_q1, w_hf, w_q3;
    logic signed [XW-1:0] h_m1, h_q1, h_hf, h_q3;
    logic signed [XW-1:0] ax, ay;

    logic signed [XW-1:0] dx_reg, dy_reg;
    logic                 vld_a_reg;
    side_t                side_a_reg;

    logic signed [DW-1:0] dxx, dyy;
    logic [DW-1:0]        dsq;
    logic [DW+3:0]        dsh;
    logic [TW-1:0]        tsum;
    logic [DDW-1:0]       dvs;
    logic                 sat;

    logic                 vld_b_reg;
    side_t                side_b_reg;
    logic [DDW-1:0]       rem_b_reg;
    logic [DDW-1:0]       dvs_b_reg;
    logic                 sat_b_reg;

    assign w3   = {1'b0, side_w, 1'b0} + (SW+2)'(side_w);
    assign h3   = {1'b0, side_h, 1'b0} + (SW+2)'(side_h);
    assign w_m1 = $signed(XW'(side_w)) - XW'(1);
    assign h_m1 = $signed(XW'(side_h)) - XW'(1);
    assign w_q1 = $signed(XW'(side_w >> 2));
    assign h_q1 = $signed(XW'(side_h >> 2));
    assign w_hf = $signed(XW'(side_w >> 1));
    assign h_hf = $signed(XW'(side_h >> 1));
    assign w_q3 = $signed(XW'(w3 >> 2));
    assign h_q3 = $signed(XW'(h3 >> 2));

    always_comb
    begin
        ax = '0;
        ay = '0;
        unique case (anchor_t'(origin))
            ORG_TOP_LEFT:  begin ax = '0;   ay = '0;   end
            ORG_LEFT_Q1:   begin ax = '0;   ay = h_q1; end
            ORG_LEFT_MID:  begin ax = '0;   ay = h_hf; end
            ORG_LEFT_Q3:   begin ax = '0;   ay = h_q3; end
            ORG_BOT_LEFT:  begin ax = '0;   ay = h_m1; end
            ORG_BOT_Q1:    begin ax = w_q1; ay = h_m1; end
            ORG_BOT_MID:   begin ax = w_hf; ay = h_m1; end
            ORG_BOT_Q3:    begin ax = w_q3; ay = h_m1; end
            ORG_BOT_RIGHT: begin ax = w_m1; ay = h_m1; end
            ORG_RIGHT_Q3:  begin ax = w_m1; ay = h_q3; end
            ORG_RIGHT_MID: begin ax = w_m1; ay = h_hf; end
            ORG_RIGHT_Q1:  begin ax = w_m1; ay = h_q1; end
            ORG_TOP_RIGHT: begin ax = w_m1; ay = '0;   end
            ORG_TOP_Q3:    begin ax = w_q3; ay = '0;   end
            ORG_TOP_MID:   begin ax = w_hf; ay = '0;   end
            ORG_TOP_Q1:    begin ax = w_q1; ay = '0;   end
            default:       begin ax = '0;   ay = '0;   end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_a_reg <= 1'b0;
            vld_b_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_a_reg <= in_vld;
            vld_b_reg <= vld_a_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dx_reg     <= $signed(XW'(pos_x)) - ax;
            dy_reg     <= $signed(XW'(pos_y)) - ay;
            side_a_reg <= in_side;
        end
    end

    assign dxx  = DW'(dx_reg) * DW'(dx_reg);
    assign dyy  = DW'(dy_reg) * DW'(dy_reg);
    assign dsq  = DW'(dxx + dyy);
    assign dsh  = {dsq, 4'b0000};
    assign tsum = TW'(side_w) * TW'(side_w) + TW'(side_h) * TW'(side_h);
    assign dvs  = (DDW'(tsum) << 4) + (DDW'(tsum) << 3) + DDW'(tsum);
    // p reaches one whenever 16d >= 25T, so the quotient then needs no division
    assign sat  = (dvs == '0) || (dsh >= (DW+4)'(dvs));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_b_reg <= side_a_reg;
            rem_b_reg  <= DDW'(dsh);
            dvs_b_reg  <= dvs;
            sat_b_reg  <= sat;
        end
    end

    assign out_vld  = vld_b_reg;
    assign out_side = side_b_reg;
    assign out_rem  = rem_b_reg;
    assign out_dvs  = dvs_b_reg;
    assign out_sat  = sat_b_reg;

endmodule

[src/rggb_qdiv.sv]
// Radix-2 restoring divider, one quotient bit per pipeline stage.
module rggb_qdiv #(
    parameter int DDW = 2 * 11 + 6
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           en,
    input  logic                           in_vld,
    input  rggb_pkg::side_t                in_side,
    input  logic [DDW-1:0]                 in_rem,
    input  logic [DDW-1:0]                 in_dvs,
    input  logic                           in_sat,
    output logic                           out_vld,
    output rggb_pkg::side_t                out_side,
    output logic [rggb_pkg::QUOT_BITS-1:0] out_quot,
    output logic                           out_sat
);
    import rggb_pkg::*;

    logic                 vld_reg  [QUOT_BITS];
    side_t                side_reg [QUOT_BITS];
    logic [DDW-1:0]       rem_reg  [QUOT_BITS];
    logic [DDW-1:0]       dvs_reg  [QUOT_BITS];
    logic [QUOT_BITS-1:0] quot_reg [QUOT_BITS];
    logic                 sat_reg  [QUOT_BITS];

    for (genvar k = 0; k < QUOT_BITS; k++)
    begin : g_stage
        logic                 vld_prev;
        side_t                side_prev;
        logic [DDW-1:0]       rem_prev;
        logic [DDW-1:0]       dvs_prev;
        logic [QUOT_BITS-1:0] quot_prev;
        logic                 sat_prev;
        logic [DDW:0]         trial;
        logic                 ge;

        if (k == 0)
        begin : g_first
            assign vld_prev  = in_vld;
            assign side_prev = in_side;
            assign rem_prev  = in_rem;
            assign dvs_prev  = in_dvs;
            assign quot_prev = '0;
            assign sat_prev  = in_sat;
        end
        else
        begin : g_rest
            assign vld_prev  = vld_reg[k-1];
            assign side_prev = side_reg[k-1];
            assign rem_prev  = rem_reg[k-1];
            assign dvs_prev  = dvs_reg[k-1];
            assign quot_prev = quot_reg[k-1];
            assign sat_prev  = sat_reg[k-1];
        end

        // low dividend bits are all zero: shift in a zero each step
        assign trial = {rem_prev, 1'b0};
        assign ge    = trial >= {1'b0, dvs_prev};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[k] <= vld_prev;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                side_reg[k] <= side_prev;
                rem_reg[k]  <= ge ? DDW'(trial - {1'b0, dvs_prev}) : DDW'(trial);
                dvs_reg[k]  <= dvs_prev;
                quot_reg[k] <= {quot_prev[QUOT_BITS-2:0], ge};
                sat_reg[k]  <= sat_prev;
            end
        end
    end

    assign out_vld  = vld_reg[QUOT_BITS-1];
    assign out_side = side_reg[QUOT_BITS-1];
    assign out_quot = quot_reg[QUOT_BITS-1];
    assign out_sat  = sat_reg[QUOT_BITS-1];

endmodule

[src/rggb_sqrt.sv]
// Digit-by-digit integer square root, one root bit per pipeline stage.
module rggb_sqrt (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           en,
    input  logic                           in_vld,
    input  rggb_pkg::side_t                in_side,
    input  logic [rggb_pkg::QUOT_BITS-1:0] in_rad,
    input  logic                           in_sat,
    output logic                           out_vld,
    output rggb_pkg::side_t                out_side,
    output logic [rggb_pkg::ROOT_BITS-1:0] out_root
);
    import rggb_pkg::*;

    localparam int RW = ROOT_BITS + 2;

    logic                 vld_reg  [ROOT_BITS];
    side_t                side_reg [ROOT_BITS];
    logic [RW-1:0]        rem_reg  [ROOT_BITS];
    logic [ROOT_BITS-1:0] root_reg [ROOT_BITS];
    logic [QUOT_BITS-1:0] rad_reg  [ROOT_BITS];
    logic                 sat_reg  [ROOT_BITS];

    for (genvar k = 0; k < ROOT_BITS; k++)
    begin : g_stage
        logic                 vld_prev;
        side_t                side_prev;
        logic [RW-1:0]        rem_prev;
        logic [ROOT_BITS-1:0] root_prev;
        logic [QUOT_BITS-1:0] rad_prev;
        logic                 sat_prev;
        logic [RW+1:0]        trial;
        logic [RW+1:0]        test;
        logic                 ge;

        if (k == 0)
        begin : g_first
            assign vld_prev  = in_vld;
            assign side_prev = in_side;
            assign rem_prev  = '0;
            assign root_prev = '0;
            assign rad_prev  = in_rad;
            assign sat_prev  = in_sat;
        end
        else
        begin : g_rest
            assign vld_prev  = vld_reg[k-1];
            assign side_prev = side_reg[k-1];
            assign rem_prev  = rem_reg[k-1];
            assign root_prev = root_reg[k-1];
            assign rad_prev  = rad_reg[k-1];
            assign sat_prev  = sat_reg[k-1];
        end

        // bring down two radicand bits, try root*4+1
        assign trial = {rem_prev, rad_prev[QUOT_BITS-1 -: 2]};
        assign test  = {2'b00, root_prev, 2'b01};
        assign ge    = trial >= test;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[k] <= vld_prev;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                side_reg[k] <= side_prev;
                rem_reg[k]  <= ge ? RW'(trial - test) : RW'(trial);
                root_reg[k] <= {root_prev[ROOT_BITS-2:0], ge};
                rad_reg[k]  <= {rad_prev[QUOT_BITS-3:0], 2'b00};
                sat_reg[k]  <= sat_prev;
            end
        end
    end

    assign out_vld  = vld_reg[ROOT_BITS-1];
    assign out_side = side_reg[ROOT_BITS-1];
    assign out_root = sat_reg[ROOT_BITS-1] ? '1 : root_reg[ROOT_BITS-1];

endmodule

[src/rggb_blend.sv]
// Gradient colour, alpha-over composite and per-channel divider pipeline.
module rggb_blend (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           en,
    input  logic                           in_vld,
    input  rggb_pkg::side_t                in_side,
    input  logic [rggb_pkg::ROOT_BITS-1:0] in_weight,
    input  logic [31:0]                    near_color,
    input  logic [31:0]                    far_color,
    output logic                           out_vld,
    output logic [7:0]                     out_blue,
    output logic [7:0]                     out_green,
    output logic [7:0]                     out_red,
    output logic [7:0]                     out_alpha
);
    import rggb_pkg::*;

    localparam int DIV_STAGES = CHAN_BITS;
    localparam int NUMW       = 3 * CHAN_BITS;
    localparam int DENW       = 2 * CHAN_BITS;

    // stage 1: gradient colour
    logic [ROOT_BITS:0]         inv_w;
    logic [3:0][CHAN_BITS-1:0]  grad;
    logic                       vld1_reg;
    side_t                      side1_reg;
    logic [3:0][CHAN_BITS-1:0]  grad1_reg;

    // stage 2: partial products
    logic                       vld2_reg;
    side_t                      side2_reg;
    logic [CHAN_BITS-1:0]       ga2_reg;
    logic [DENW-1:0]            sa2_reg;
    logic [2:0][DENW-1:0]       gg2_reg;

    // stage 3: numerators and denominator
    logic [DENW-1:0]            den;
    logic [2:0][NUMW-1:0]       num;
    logic [2:0][CHAN_BITS-1:0]  pix;
    logic [DENW:0]              asum;
    logic                       vld3_reg;
    side_t                      side3_reg;
    logic [DENW-1:0]            den3_reg;
    logic [2:0][NUMW-1:0]       num3_reg;
    logic [CHAN_BITS-1:0]       alpha3_reg;

    // division stages
    logic                            vld_reg   [DIV_STAGES];
    side_t                           side_reg  [DIV_STAGES];
    logic [DENW-1:0]                 den_reg   [DIV_STAGES];
    logic [CHAN_BITS-1:0]            alpha_reg [DIV_STAGES];
    logic [2:0][DENW-1:0]            rem_reg   [DIV_STAGES];
    logic [2:0][CHAN_BITS-1:0]       low_reg   [DIV_STAGES];
    logic [2:0][CHAN_BITS-1:0]       quot_reg  [DIV_STAGES];

    assign inv_w = (ROOT_BITS+1)'(1 << ROOT_BITS) - {1'b0, in_weight};

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            grad[k] = CHAN_BITS'(((25'(near_color[8*k +: 8]) * 25'(inv_w))
                                + (25'(far_color[8*k +: 8]) * 25'(in_weight))) >> ROOT_BITS);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
            vld3_reg <= 1'b0;
        end
        else if (en)
        begin
            vld1_reg <= in_vld;
            vld2_reg <= vld1_reg;
            vld3_reg <= vld2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side1_reg <= in_side;
            grad1_reg <= grad;

            side2_reg <= side1_reg;
            ga2_reg   <= grad1_reg[3];
            sa2_reg   <= DENW'(side1_reg.alpha) * DENW'(8'd255 - grad1_reg[3]);
            for (int k = 0; k < 3; k++)
            begin
                gg2_reg[k] <= DENW'(grad1_reg[k]) * DENW'(grad1_reg[3]);
            end
        end
    end

    assign pix[0] = side2_reg.blue;
    assign pix[1] = side2_reg.green;
    assign pix[2] = side2_reg.red;
    assign den    = DENW'(({1'b0, ga2_reg, 8'h00} - (DENW+1)'(ga2_reg)) + (DENW+1)'(sa2_reg));

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            num[k] = ((NUMW'(gg2_reg[k]) << 8) - NUMW'(gg2_reg[k]))
                   + NUMW'(pix[k]) * NUMW'(sa2_reg);
        end
    end

    // den / 255 for den up to 255*255
    assign asum = (DENW+1)'(den) + (DENW+1)'(1) + (DENW+1)'(den >> 8);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side3_reg  <= side2_reg;
            den3_reg   <= den;
            num3_reg   <= num;
            alpha3_reg <= CHAN_BITS'(asum >> 8);
        end
    end

    for (genvar s = 0; s < DIV_STAGES; s++)
    begin : g_div
        logic                      vld_prev;
        side_t                     side_prev;
        logic [DENW-1:0]           den_prev;
        logic [CHAN_BITS-1:0]      alpha_prev;
        logic [2:0][DENW-1:0]      rem_prev;
        logic [2:0][CHAN_BITS-1:0] low_prev;
        logic [2:0][CHAN_BITS-1:0] quot_prev;
        logic [2:0][DENW-1:0]      rem_next;
        logic [2:0][CHAN_BITS-1:0] quot_next;

        if (s == 0)
        begin : g_first
            assign vld_prev   = vld3_reg;
            assign side_prev  = side3_reg;
            assign den_prev   = den3_reg;
            assign alpha_prev = alpha3_reg;
            assign quot_prev  = '0;
            for (genvar c = 0; c < 3; c++)
            begin : g_ch
                assign rem_prev[c] = num3_reg[c][NUMW-1:CHAN_BITS];
                assign low_prev[c] = num3_reg[c][CHAN_BITS-1:0];
            end
        end
        else
        begin : g_rest
            assign vld_prev   = vld_reg[s-1];
            assign side_prev  = side_reg[s-1];
            assign den_prev   = den_reg[s-1];
            assign alpha_prev = alpha_reg[s-1];
            assign rem_prev   = rem_reg[s-1];
            assign low_prev   = low_reg[s-1];
            assign quot_prev  = quot_reg[s-1];
        end

        always_comb
        begin
            logic [DENW:0] trial;
            logic          ge;
            for (int c = 0; c < 3; c++)
            begin
                trial        = {rem_prev[c], low_prev[c][CHAN_BITS-1]};
                ge           = trial >= {1'b0, den_prev};
                rem_next[c]  = ge ? DENW'(trial - {1'b0, den_prev}) : DENW'(trial);
                quot_next[c] = {quot_prev[c][CHAN_BITS-2:0], ge};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[s] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[s] <= vld_prev;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                side_reg[s]  <= side_prev;
                den_reg[s]   <= den_prev;
                alpha_reg[s] <= alpha_prev;
                rem_reg[s]   <= rem_next;
                quot_reg[s]  <= quot_next;
                for (int c = 0; c < 3; c++)
                begin
                    low_reg[s][c] <= {low_prev[c][CHAN_BITS-2:0], 1'b0};
                end
            end
        end
    end

    // transparent pixels pass their own bytes
    assign out_vld   = vld_reg[DIV_STAGES-1];
    assign out_blue  = side_reg[DIV_STAGES-1].bypass ? side_reg[DIV_STAGES-1].blue
                                                     : quot_reg[DIV_STAGES-1][0];
    assign out_green = side_reg[DIV_STAGES-1].bypass ? side_reg[DIV_STAGES-1].green
                                                     : quot_reg[DIV_STAGES-1][1];
    assign out_red   = side_reg[DIV_STAGES-1].bypass ? side_reg[DIV_STAGES-1].red
                                                     : quot_reg[DIV_STAGES-1][2];
    assign out_alpha = side_reg[DIV_STAGES-1].bypass ? '0 : alpha_reg[DIV_STAGES-1];

    a_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        vld3_reg && !side3_reg.bypass |-> den3_reg != '0)
        else $error("composite denominator is zero");

    a_quot_fits: assert property (@(posedge clk) disable iff (!rst_n)
        vld3_reg && !side3_reg.bypass |->
            (num3_reg[0][NUMW-1:CHAN_BITS] < den3_reg)
            && (num3_reg[1][NUMW-1:CHAN_BITS] < den3_reg)
            && (num3_reg[2][NUMW-1:CHAN_BITS] < den3_reg))
        else $error("colour quotient overflows eight bits");

    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[DIV_STAGES-1] && !side_reg[DIV_STAGES-1].bypass |->
            (rem_reg[DIV_STAGES-1][0] < den_reg[DIV_STAGES-1])
            && (rem_reg[DIV_STAGES-1][1] < den_reg[DIV_STAGES-1])
            && (rem_reg[DIV_STAGES-1][2] < den_reg[DIV_STAGES-1]))
        else $error("division remainder not below denominator");

    a_alpha_floor: assert property (@(posedge clk) disable iff (!rst_n)
        vld3_reg && !side3_reg.bypass |->
            (16'(alpha3_reg) * 16'd255 <= den3_reg)
            && (den3_reg - 16'(alpha3_reg) * 16'd255 < 16'd255))
        else $error("alpha is not den divided by 255");

endmodule

[src/radial_gradient_glow_blend_unit.sv]
// Top level of the radial glow blend: configuration registers and pipeline chain.
//
// Usage: requests carry one BGRA pixel with its column and row on the input
// channel (in_valid/in_ready); each request yields exactly one blended pixel
// on the output channel (out_valid/out_ready), in order.
// A pixel with zero alpha comes out with its colour bytes unchanged and alpha 0.
// Configuration (width, height, anchor, near and far colour) is written through
// wr_en/wr_index/wr_data, one register per cycle, while no request is in flight.
// From acceptance to out_valid a pixel passes the geometry stages, the 32-stage
// quotient divider, the 16-stage square root, the composite stages and the 8-stage colour divider.
// Throughput: one pixel per clock, sustained while the output is not stalled.
// Stall: while out_valid is high and out_ready low the whole pipeline holds;
// in_ready falls, no request is lost or repeated, bubbles are kept.
// Reset: rst_n clears every valid bit and loads width 256, height 256, anchor
// top-left, near colour A0FFFFFF and far colour 8C00E1B5.
module radial_gradient_glow_blend_unit #(
    parameter int MAX_SIDE = rggb_pkg::MAX_SIDE_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        wr_en,
    input  logic [2:0]  wr_index,
    input  logic [31:0] wr_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [9:0]  pos_x,
    input  logic [9:0]  pos_y,
    input  logic [7:0]  in_blue,
    input  logic [7:0]  in_green,
    input  logic [7:0]  in_red,
    input  logic [7:0]  in_alpha,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_blue,
    output logic [7:0]  out_green,
    output logic [7:0]  out_red,
    output logic [7:0]  out_alpha
);
    import rggb_pkg::*;

    localparam int SW  = $clog2(MAX_SIDE + 1);
    localparam int XW  = ((SW > 10) ? SW : 10) + 2;
    localparam int DDW = 2 * SW + 6;

    typedef enum logic [2:0] {
        REG_WIDTH  = 3'd0,
        REG_HEIGHT = 3'd1,
        REG_ORIGIN = 3'd2,
        REG_NEAR   = 3'd3,
        REG_FAR    = 3'd4
    } cfg_idx_t;

    logic [10:0] image_width_reg;
    logic [10:0] image_height_reg;
    logic [3:0]  origin_reg;
    logic [31:0] near_color_reg;
    logic [31:0] far_color_reg;

    logic [SW-1:0] side_w;
    logic [SW-1:0] side_h;
    logic          en;
    side_t         in_side;

    logic           g_vld;
    side_t          g_side;
    logic [DDW-1:0] g_rem;
    logic [DDW-1:0] g_dvs;
    logic           g_sat;

    logic                 q_vld;
    side_t                q_side;
    logic [QUOT_BITS-1:0] q_quot;
    logic                 q_sat;

    logic                 r_vld;
    side_t                r_side;
    logic [ROOT_BITS-1:0] r_root;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= 11'd256;
            image_height_reg <= 11'd256;
            origin_reg       <= 4'd0;
            near_color_reg   <= 32'hA0FF_FFFF;
            far_color_reg    <= 32'h8C00_E1B5;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_WIDTH:  image_width_reg  <= wr_data[10:0];
                REG_HEIGHT: image_height_reg <= wr_data[10:0];
                REG_ORIGIN: origin_reg       <= wr_data[3:0];
                REG_NEAR:   near_color_reg   <= wr_data;
                REG_FAR:    far_color_reg    <= wr_data;
                default:    ;
            endcase
        end
    end

    assign side_w = ({21'd0, image_width_reg} > 32'(MAX_SIDE)) ? SW'(MAX_SIDE)
                                                               : SW'(image_width_reg);
    assign side_h = ({21'd0, image_height_reg} > 32'(MAX_SIDE)) ? SW'(MAX_SIDE)
                                                                : SW'(image_height_reg);

    // advance everything unless a finished pixel is waiting
    assign en       = !out_valid || out_ready;
    assign in_ready = en;

    assign in_side.bypass = (in_alpha == 8'd0);
    assign in_side.alpha  = in_alpha;
    assign in_side.red    = in_red;
    assign in_side.green  = in_green;
    assign in_side.blue   = in_blue;

    rggb_geom #(
        .MAX_SIDE (MAX_SIDE),
        .SW       (SW),
        .XW       (XW),
        .DDW      (DDW)
    ) u_geom (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (in_valid && in_ready),
        .in_side  (in_side),
        .pos_x    (pos_x),
        .pos_y    (pos_y),
        .side_w   (side_w),
        .side_h   (side_h),
        .origin   (origin_reg),
        .out_vld  (g_vld),
        .out_side (g_side),
        .out_rem  (g_rem),
        .out_dvs  (g_dvs),
        .out_sat  (g_sat)
    );

    rggb_qdiv #(
        .DDW (DDW)
    ) u_qdiv (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (g_vld),
        .in_side  (g_side),
        .in_rem   (g_rem),
        .in_dvs   (g_dvs),
        .in_sat   (g_sat),
        .out_vld  (q_vld),
        .out_side (q_side),
        .out_quot (q_quot),
        .out_sat  (q_sat)
    );

    rggb_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (q_vld),
        .in_side  (q_side),
        .in_rad   (q_quot),
        .in_sat   (q_sat),
        .out_vld  (r_vld),
        .out_side (r_side),
        .out_root (r_root)
    );

    rggb_blend u_blend (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .in_vld     (r_vld),
        .in_side    (r_side),
        .in_weight  (r_root),
        .near_color (near_color_reg),
        .far_color  (far_color_reg),
        .out_vld    (out_valid),
        .out_blue   (out_blue),
        .out_green  (out_green),
        .out_red    (out_red),
        .out_alpha  (out_alpha)
    );

endmodule
